@@ sv/tcf_pkg.sv @@
// ----------------------------------------------------------------------------
// TCP connection table package
// Types, command and status codes, slot state codes and register reset values
// that are shared by the table's front end, back end and top level.
// ----------------------------------------------------------------------------
package tcf_pkg;

    localparam logic [2:0] CMD_SEG     = 3'd0;
    localparam logic [2:0] CMD_LISTEN  = 3'd1;
    localparam logic [2:0] CMD_CONNECT = 3'd2;
    localparam logic [2:0] CMD_SEND    = 3'd3;
    localparam logic [2:0] CMD_CLOSE   = 3'd4;
    localparam logic [2:0] CMD_CONSUME = 3'd5;

    localparam logic [2:0] STS_OK        = 3'd0;
    localparam logic [2:0] STS_BAD_ARG   = 3'd1;
    localparam logic [2:0] STS_NO_ROOM   = 3'd2;
    localparam logic [2:0] STS_BAD_STATE = 3'd3;
    localparam logic [2:0] STS_NOT_FOUND = 3'd4;
    localparam logic [2:0] STS_NO_DATA   = 3'd5;
    localparam logic [2:0] STS_TOO_BIG   = 3'd6;

    localparam logic [3:0] ST_UNUSED     = 4'd0;
    localparam logic [3:0] ST_LISTEN     = 4'd2;
    localparam logic [3:0] ST_SYN_SENT   = 4'd3;
    localparam logic [3:0] ST_SYN_RCVD   = 4'd4;
    localparam logic [3:0] ST_ESTAB      = 4'd5;
    localparam logic [3:0] ST_FIN_WAIT   = 4'd6;
    localparam logic [3:0] ST_CLOSE_WAIT = 4'd7;
    localparam logic [3:0] ST_LAST_ACK   = 4'd8;

    localparam logic [7:0] FL_FIN = 8'h01;
    localparam logic [7:0] FL_SYN = 8'h02;
    localparam logic [7:0] FL_PSH = 8'h08;
    localparam logic [7:0] FL_ACK = 8'h10;

    localparam logic [1:0] CFG_EPH_BASE    = 2'd0;
    localparam logic [1:0] CFG_INIT_SEQ    = 2'd1;
    localparam logic [1:0] CFG_MAX_CONNS   = 2'd2;
    localparam logic [1:0] CFG_MAX_PAYLOAD = 2'd3;

    localparam logic [15:0] RST_EPH_BASE    = 16'd1077;
    localparam logic [31:0] RST_INIT_SEQ    = 32'h1234_5000;
    localparam logic [3:0]  RST_MAX_CONNS   = 4'd8;
    localparam logic [10:0] RST_MAX_PAYLOAD = 11'd1460;

    typedef struct packed {
        logic [15:0] eph_base;
        logic [31:0] init_seq;
        logic [3:0]  max_conns;
        logic [10:0] max_payload;
    } t_cfg;

    typedef struct packed {
        logic        bad;
        logic [2:0]  cmd;
        logic [2:0]  sel;
        logic [15:0] lport;
        logic [31:0] rip;
        logic [15:0] rport;
        logic [31:0] seq;
        logic [31:0] ack;
        logic [7:0]  flags;
        logic [15:0] plen;
        logic [15:0] bcount;
    } t_item;

    typedef struct packed {
        logic [2:0]  status;
        logic [2:0]  slot;
        logic        emit_valid;
        logic [7:0]  emit_flags;
        logic [31:0] emit_seq;
        logic [31:0] emit_ack;
        logic [15:0] emit_lport;
        logic [15:0] dest_port;
        logic [31:0] peer_ip;
        logic [12:0] granted;
        logic        last;
    } t_result;

endpackage

@@ sv/tcf_front.sv @@
// ----------------------------------------------------------------------------
// TCP connection table front end
// Accepts command beats, flags malformed commands and holds them in a
// two-entry queue until the back end takes them.
// ----------------------------------------------------------------------------
module tcf_front #(
    parameter int NUM_SLOTS = 8
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           push,
    output logic           full,
    input  logic [2:0]     i_cmd,
    input  logic [2:0]     i_slot_sel,
    input  logic [15:0]    i_local_port,
    input  logic [31:0]    i_remote_ip,
    input  logic [15:0]    i_remote_port,
    input  logic [31:0]    i_seq_number,
    input  logic [31:0]    i_ack_number,
    input  logic [7:0]     i_segment_flags,
    input  logic [15:0]    i_payload_length,
    input  logic [15:0]    i_byte_count,
    output logic           o_valid,
    input  logic           i_take,
    output tcf_pkg::t_item o_item
);
    import tcf_pkg::*;

    t_item      r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    t_item      w_item;
    logic       w_push_ok;
    logic       w_pop_ok;

    always_comb begin
        w_item.cmd    = i_cmd;
        w_item.sel    = i_slot_sel;
        w_item.lport  = i_local_port;
        w_item.rip    = i_remote_ip;
        w_item.rport  = i_remote_port;
        w_item.seq    = i_seq_number;
        w_item.ack    = i_ack_number;
        w_item.flags  = i_segment_flags;
        w_item.plen   = i_payload_length;
        w_item.bcount = i_byte_count;
        w_item.bad    = 1'b0;
        if (i_cmd > CMD_CONSUME) begin
            w_item.bad = 1'b1;
        end else if (i_cmd == CMD_LISTEN && i_local_port == 16'd0) begin
            w_item.bad = 1'b1;
        end else if (i_cmd == CMD_CONNECT && i_remote_port == 16'd0) begin
            w_item.bad = 1'b1;
        end else if (i_cmd inside {[CMD_SEND:CMD_CONSUME]} &&
                     32'(i_slot_sel) >= 32'(NUM_SLOTS)) begin
            w_item.bad = 1'b1;
        end
    end

    assign full      = (r_cnt == 2'd2);
    assign o_valid   = (r_cnt != 2'd0);
    assign o_item    = r_q[r_rp];
    assign w_push_ok = push && !full;
    assign w_pop_ok  = o_valid && i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push_ok) begin
                r_wp <= ~r_wp;
            end
            if (w_pop_ok) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(w_push_ok) - 2'(w_pop_ok);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push_ok) begin
            r_q[r_wp] <= w_item;
        end
    end

endmodule

@@ sv/tcf_back.sv @@
// ----------------------------------------------------------------------------
// TCP connection table back end
// Walks the table for a matching or free slot or takes the selected slot,
// applies the connection state transitions to it and queues the result beats.
// ----------------------------------------------------------------------------
module tcf_back #(
    parameter int NUM_SLOTS = 8,
    parameter int RX_CAP    = 4096,
    parameter int TX_CAP    = 4096
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  tcf_pkg::t_cfg    i_cfg,
    input  logic             i_valid,
    input  tcf_pkg::t_item   i_item,
    output logic             o_take,
    output logic             o_empty,
    input  logic             i_pop,
    output tcf_pkg::t_result o_res
);
    import tcf_pkg::*;

    localparam int IW     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int SW     = (IW > 3) ? IW : 3;
    localparam int UW     = $clog2(NUM_SLOTS + 1);
    localparam int CAPMAX = (RX_CAP > TX_CAP) ? RX_CAP : TX_CAP;
    localparam int FW     = $clog2(CAPMAX + 1);
    localparam logic [16:0] RX_CAP17 = 17'(RX_CAP);
    localparam logic [16:0] TX_CAP17 = 17'(TX_CAP);
    localparam logic [IW-1:0] LAST_IDX = IW'(NUM_SLOTS - 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_WALK = 2'd1;
    localparam logic [1:0] S_EXEC = 2'd2;

    logic [1:0]    r_state;
    t_item         r_item;
    logic [IW-1:0] r_idx;
    logic          r_hit;
    logic [UW-1:0] r_used;

    logic [3:0]    r_st    [NUM_SLOTS];
    logic [15:0]   r_lport [NUM_SLOTS];
    logic [31:0]   r_pip   [NUM_SLOTS];
    logic [15:0]   r_pport [NUM_SLOTS];
    logic [31:0]   r_snd   [NUM_SLOTS];
    logic [31:0]   r_rcv   [NUM_SLOTS];
    logic [FW-1:0] r_rxf   [NUM_SLOTS];
    logic [FW-1:0] r_txf   [NUM_SLOTS];

    t_result r_oq [2];
    logic    r_ohead;
    logic [1:0] r_ocnt;

    logic [3:0]    c_st;
    logic [15:0]   c_lport;
    logic [31:0]   c_pip;
    logic [15:0]   c_pport;
    logic [31:0]   c_snd;
    logic [31:0]   c_rcv;
    logic [FW-1:0] c_rxf;
    logic [FW-1:0] c_txf;

    logic [3:0]    n_st;
    logic [15:0]   n_lport;
    logic [31:0]   n_pip;
    logic [15:0]   n_pport;
    logic [31:0]   n_snd;
    logic [31:0]   n_rcv;
    logic [FW-1:0] n_rxf;
    logic [FW-1:0] n_txf;

    t_result w_res0;
    t_result w_res1;
    logic    w_two;
    logic    w_alloc;
    logic    w_free;
    logic    w_match;
    logic    w_commit;
    logic [SW-1:0] w_idx_w;
    logic [2:0]    w_slot3;
    logic [SW-1:0] w_sel_w;
    logic [31:0]   w_isn;
    logic [31:0]   w_ack1;
    logic [16:0]   w_room;
    logic [16:0]   w_copy;
    logic [16:0]   w_tsum;
    logic [16:0]   w_grant;

    function automatic t_result mk_emit(input logic [2:0] slot, input logic [7:0] fl,
                                        input logic [31:0] sq, input logic [31:0] ak,
                                        input logic [15:0] lp, input logic [15:0] pp,
                                        input logic [31:0] pi);
        t_result r;
        r            = '0;
        r.status     = STS_OK;
        r.slot       = slot;
        r.emit_valid = 1'b1;
        r.emit_flags = fl;
        r.emit_seq   = sq;
        r.emit_ack   = ak;
        r.emit_lport = lp;
        r.dest_port  = pp;
        r.peer_ip    = pi;
        return r;
    endfunction

    assign c_st    = r_st[r_idx];
    assign c_lport = r_lport[r_idx];
    assign c_pip   = r_pip[r_idx];
    assign c_pport = r_pport[r_idx];
    assign c_snd   = r_snd[r_idx];
    assign c_rcv   = r_rcv[r_idx];
    assign c_rxf   = r_rxf[r_idx];
    assign c_txf   = r_txf[r_idx];

    assign w_idx_w = SW'(r_idx);
    assign w_slot3 = w_idx_w[2:0];
    assign w_sel_w = SW'(i_item.sel);
    assign w_isn   = i_cfg.init_seq + 32'(r_idx);

    assign o_take   = (r_state == S_IDLE);
    assign w_commit = (r_state == S_EXEC) && (r_ocnt == 2'd0);
    assign o_empty  = (r_ocnt == 2'd0);
    assign o_res    = r_oq[r_ohead];

    always_comb begin
        if (r_item.cmd == CMD_SEG) begin
            w_match = (c_st != ST_UNUSED) && (c_lport == r_item.lport) &&
                      ((c_st == ST_LISTEN) ||
                       (c_pport == r_item.rport && c_pip == r_item.rip));
        end else begin
            w_match = (c_st == ST_UNUSED);
        end
    end

    always_comb begin
        n_st    = c_st;
        n_lport = c_lport;
        n_pip   = c_pip;
        n_pport = c_pport;
        n_snd   = c_snd;
        n_rcv   = c_rcv;
        n_rxf   = c_rxf;
        n_txf   = c_txf;
        w_res0  = '0;
        w_res1  = '0;
        w_two   = 1'b0;
        w_alloc = 1'b0;
        w_free  = 1'b0;
        w_ack1  = (r_item.plen != 16'd0) ? (r_item.seq + 32'(r_item.plen)) : c_rcv;
        w_room  = RX_CAP17 - 17'(c_rxf);
        w_copy  = (17'(r_item.plen) < w_room) ? 17'(r_item.plen) : w_room;
        w_tsum  = 17'(c_txf) + 17'(r_item.bcount);
        w_grant = (17'(c_rxf) < 17'(r_item.bcount)) ? 17'(c_rxf) : 17'(r_item.bcount);
        if (r_item.bad) begin
            w_res0.status = STS_BAD_ARG;
        end else begin
            case (r_item.cmd)
                CMD_SEG: begin
                    if (!r_hit) begin
                        w_res0.status = STS_NOT_FOUND;
                    end else begin
                        w_res0.slot = w_slot3;
                        case (c_st)
                            ST_LISTEN: begin
                                if ((r_item.flags & FL_SYN) != 8'd0) begin
                                    n_pip   = r_item.rip;
                                    n_pport = r_item.rport;
                                    n_rcv   = r_item.seq + 32'd1;
                                    n_snd   = w_isn + 32'd1;
                                    n_st    = ST_SYN_RCVD;
                                    w_res0  = mk_emit(w_slot3, FL_SYN | FL_ACK, w_isn,
                                                      r_item.seq + 32'd1, c_lport,
                                                      r_item.rport, r_item.rip);
                                end
                            end
                            ST_SYN_SENT: begin
                                if ((r_item.flags & (FL_SYN | FL_ACK)) ==
                                    (FL_SYN | FL_ACK)) begin
                                    n_rcv  = r_item.seq + 32'd1;
                                    n_st   = ST_ESTAB;
                                    w_res0 = mk_emit(w_slot3, FL_ACK, c_snd,
                                                     r_item.seq + 32'd1, c_lport,
                                                     c_pport, c_pip);
                                end
                            end
                            ST_SYN_RCVD: begin
                                if ((r_item.flags & FL_ACK) != 8'd0) begin
                                    n_st = ST_ESTAB;
                                end
                            end
                            ST_ESTAB: begin
                                n_rcv = w_ack1;
                                if (r_item.plen != 16'd0) begin
                                    n_rxf  = FW'(17'(c_rxf) + w_copy);
                                    w_res0 = mk_emit(w_slot3, FL_ACK, c_snd, w_ack1,
                                                     c_lport, c_pport, c_pip);
                                end
                                if ((r_item.flags & FL_FIN) != 8'd0) begin
                                    n_rcv = w_ack1 + 32'd1;
                                    n_st  = ST_CLOSE_WAIT;
                                    if (r_item.plen != 16'd0) begin
                                        w_two  = 1'b1;
                                        w_res1 = mk_emit(w_slot3, FL_ACK, c_snd,
                                                         w_ack1 + 32'd1, c_lport,
                                                         c_pport, c_pip);
                                    end else begin
                                        w_res0 = mk_emit(w_slot3, FL_ACK, c_snd,
                                                         w_ack1 + 32'd1, c_lport,
                                                         c_pport, c_pip);
                                    end
                                end
                            end
                            ST_FIN_WAIT: begin
                                if ((r_item.flags & FL_FIN) != 8'd0) begin
                                    w_res0 = mk_emit(w_slot3, FL_ACK, c_snd,
                                                     c_rcv + 32'd1, c_lport,
                                                     c_pport, c_pip);
                                    n_st   = ST_UNUSED;
                                    w_free = 1'b1;
                                end
                            end
                            ST_LAST_ACK: begin
                                if ((r_item.flags & FL_ACK) != 8'd0) begin
                                    n_st   = ST_UNUSED;
                                    w_free = 1'b1;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                CMD_LISTEN, CMD_CONNECT: begin
                    if (!r_hit) begin
                        w_res0.status = STS_NO_ROOM;
                    end else begin
                        w_alloc     = 1'b1;
                        w_res0.slot = w_slot3;
                        n_rxf       = '0;
                        n_txf       = '0;
                        n_rcv       = 32'd0;
                        if (r_item.cmd == CMD_LISTEN) begin
                            n_st    = ST_LISTEN;
                            n_lport = r_item.lport;
                            n_pip   = 32'd0;
                            n_pport = 16'd0;
                            n_snd   = 32'd0;
                        end else begin
                            n_st    = ST_SYN_SENT;
                            n_lport = i_cfg.eph_base + 16'(r_idx);
                            n_pip   = r_item.rip;
                            n_pport = r_item.rport;
                            n_snd   = w_isn + 32'd1;
                            w_res0  = mk_emit(w_slot3, FL_SYN, w_isn, 32'd0,
                                              i_cfg.eph_base + 16'(r_idx),
                                              r_item.rport, r_item.rip);
                        end
                    end
                end
                CMD_SEND: begin
                    w_res0.slot = w_slot3;
                    if (c_st != ST_ESTAB) begin
                        w_res0.status = STS_BAD_STATE;
                    end else if (w_tsum > TX_CAP17) begin
                        w_res0.status = STS_NO_ROOM;
                    end else begin
                        n_txf = FW'(w_tsum);
                        if (r_item.bcount > 16'(i_cfg.max_payload)) begin
                            w_res0.status = STS_TOO_BIG;
                        end else begin
                            n_snd  = c_snd + 32'(r_item.bcount);
                            w_res0 = mk_emit(w_slot3, FL_PSH | FL_ACK, c_snd, c_rcv,
                                             c_lport, c_pport, c_pip);
                        end
                    end
                end
                CMD_CLOSE: begin
                    w_res0.slot = w_slot3;
                    case (c_st)
                        ST_UNUSED: begin
                            w_res0.status = STS_BAD_ARG;
                        end
                        ST_LISTEN, ST_SYN_SENT: begin
                            n_st   = ST_UNUSED;
                            w_free = 1'b1;
                        end
                        ST_ESTAB, ST_SYN_RCVD, ST_CLOSE_WAIT: begin
                            n_snd  = c_snd + 32'd1;
                            n_st   = (c_st == ST_CLOSE_WAIT) ? ST_LAST_ACK : ST_FIN_WAIT;
                            w_res0 = mk_emit(w_slot3, FL_FIN | FL_ACK, c_snd, c_rcv,
                                             c_lport, c_pport, c_pip);
                        end
                        default: begin
                        end
                    endcase
                end
                CMD_CONSUME: begin
                    w_res0.slot = w_slot3;
                    if (c_st == ST_UNUSED) begin
                        w_res0.status = STS_BAD_STATE;
                    end else if (c_rxf == '0) begin
                        w_res0.status = STS_NO_DATA;
                    end else begin
                        n_rxf            = FW'(17'(c_rxf) - w_grant);
                        w_res0.dest_port = c_pport;
                        w_res0.peer_ip   = c_pip;
                        w_res0.granted   = w_grant[12:0];
                    end
                end
                default: begin
                    w_res0.status = STS_BAD_ARG;
                end
            endcase
        end
        w_res0.last = !w_two;
        w_res1.last = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_hit   <= 1'b0;
            r_idx   <= '0;
            r_used  <= '0;
            r_ohead <= 1'b0;
            r_ocnt  <= 2'd0;
            for (int k = 0; k < NUM_SLOTS; k++) begin
                r_st[k] <= ST_UNUSED;
            end
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_idx <= '0;
                        r_hit <= 1'b0;
                        if (i_item.bad) begin
                            r_state <= S_EXEC;
                        end else if (i_item.cmd == CMD_SEG) begin
                            r_state <= S_WALK;
                        end else if (i_item.cmd == CMD_LISTEN ||
                                     i_item.cmd == CMD_CONNECT) begin
                            if (32'(r_used) >= 32'(i_cfg.max_conns)) begin
                                r_state <= S_EXEC;
                            end else begin
                                r_state <= S_WALK;
                            end
                        end else begin
                            r_idx   <= w_sel_w[IW-1:0];
                            r_hit   <= 1'b1;
                            r_state <= S_EXEC;
                        end
                    end
                end
                S_WALK: begin
                    if (w_match) begin
                        r_hit   <= 1'b1;
                        r_state <= S_EXEC;
                    end else if (r_idx == LAST_IDX) begin
                        r_state <= S_EXEC;
                    end else begin
                        r_idx <= r_idx + IW'(1);
                    end
                end
                S_EXEC: begin
                    if (w_commit) begin
                        r_st[r_idx] <= n_st;
                        r_used      <= r_used + UW'(w_alloc) - UW'(w_free);
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            if (w_commit) begin
                r_ohead <= 1'b0;
                r_ocnt  <= w_two ? 2'd2 : 2'd1;
            end else if (i_pop && !o_empty) begin
                r_ohead <= ~r_ohead;
                r_ocnt  <= r_ocnt - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_valid) begin
            r_item <= i_item;
        end
        if (w_commit) begin
            r_lport[r_idx] <= n_lport;
            r_pip[r_idx]   <= n_pip;
            r_pport[r_idx] <= n_pport;
            r_snd[r_idx]   <= n_snd;
            r_rcv[r_idx]   <= n_rcv;
            r_rxf[r_idx]   <= n_rxf;
            r_txf[r_idx]   <= n_txf;
            r_oq[0]        <= w_res0;
            r_oq[1]        <= w_res1;
        end
    end

`ifndef SYNTHESIS
    logic [NUM_SLOTS-1:0] a_used_vec;

    always_comb begin
        for (int k = 0; k < NUM_SLOTS; k++) begin
            a_used_vec[k] = (r_st[k] != ST_UNUSED);
        end
    end

    a_used_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_used) == $countones(a_used_vec))
        else $error("slot use count disagrees with the slot table");

    a_ocnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ocnt != 2'd3)
        else $error("result queue holds more than two beats");

    a_walk_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> (!r_item.bad && (r_item.cmd == CMD_SEG ||
            r_item.cmd == CMD_LISTEN || r_item.cmd == CMD_CONNECT)))
        else $error("slot walk started for a command that needs none");

    a_exec_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_commit |=> (r_state == S_IDLE && r_ocnt != 2'd0))
        else $error("commit did not queue its results");
`endif

endmodule

@@ sv/tcp_connection_table_fsm.sv @@
// ----------------------------------------------------------------------------
// TCP connection table
// Connection slot table with a simplified TCP state machine, a command queue
// in front and a result queue behind.
// ----------------------------------------------------------------------------
// Commands enter through a two-beat queue and are handled one at a time.
// An inbound segment, listen or connect walks the slot table one slot per
// cycle to find a matching or free slot; a listen or connect skips the walk
// when malformed or with max_conns slots in use. Send, close and consume go
// straight to their slot. Each command then writes its slot once and places
// one or two result beats in a two-beat result queue; the next command is
// committed only once that queue has drained. No clearing pass follows reset.
module tcp_connection_table_fsm #(
    parameter int NUM_SLOTS = 8,
    parameter int RX_CAP    = 4096,
    parameter int TX_CAP    = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        push,
    output logic        full,
    input  logic [2:0]  i_cmd,
    input  logic [2:0]  i_slot_sel,
    input  logic [15:0] i_local_port,
    input  logic [31:0] i_remote_ip,
    input  logic [15:0] i_remote_port,
    input  logic [31:0] i_seq_number,
    input  logic [31:0] i_ack_number,
    input  logic [7:0]  i_segment_flags,
    input  logic [15:0] i_payload_length,
    input  logic [15:0] i_byte_count,
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  o_status,
    output logic [2:0]  o_slot,
    output logic        o_emit_valid,
    output logic [7:0]  o_emit_flags,
    output logic [31:0] o_emit_seq,
    output logic [31:0] o_emit_ack,
    output logic [15:0] o_emit_local_port,
    output logic [15:0] o_dest_port,
    output logic [31:0] o_peer_ip,
    output logic [12:0] o_granted_count,
    output logic        o_last
);
    import tcf_pkg::*;

    t_cfg    r_cfg;
    t_item   w_item;
    t_result w_res;
    logic    w_valid;
    logic    w_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.eph_base    <= RST_EPH_BASE;
            r_cfg.init_seq    <= RST_INIT_SEQ;
            r_cfg.max_conns   <= RST_MAX_CONNS;
            r_cfg.max_payload <= RST_MAX_PAYLOAD;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_EPH_BASE:    r_cfg.eph_base    <= i_cfg_data[15:0];
                CFG_INIT_SEQ:    r_cfg.init_seq    <= i_cfg_data;
                CFG_MAX_CONNS:   r_cfg.max_conns   <= i_cfg_data[3:0];
                CFG_MAX_PAYLOAD: r_cfg.max_payload <= i_cfg_data[10:0];
                default: begin
                end
            endcase
        end
    end

    tcf_front #(
        .NUM_SLOTS(NUM_SLOTS)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .push            (push),
        .full            (full),
        .i_cmd           (i_cmd),
        .i_slot_sel      (i_slot_sel),
        .i_local_port    (i_local_port),
        .i_remote_ip     (i_remote_ip),
        .i_remote_port   (i_remote_port),
        .i_seq_number    (i_seq_number),
        .i_ack_number    (i_ack_number),
        .i_segment_flags (i_segment_flags),
        .i_payload_length(i_payload_length),
        .i_byte_count    (i_byte_count),
        .o_valid         (w_valid),
        .i_take          (w_take),
        .o_item          (w_item)
    );

    tcf_back #(
        .NUM_SLOTS(NUM_SLOTS),
        .RX_CAP   (RX_CAP),
        .TX_CAP   (TX_CAP)
    ) u_back (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg  (r_cfg),
        .i_valid(w_valid),
        .i_item (w_item),
        .o_take (w_take),
        .o_empty(empty),
        .i_pop  (pop),
        .o_res  (w_res)
    );

    assign o_status          = w_res.status;
    assign o_slot            = w_res.slot;
    assign o_emit_valid      = w_res.emit_valid;
    assign o_emit_flags      = w_res.emit_flags;
    assign o_emit_seq        = w_res.emit_seq;
    assign o_emit_ack        = w_res.emit_ack;
    assign o_emit_local_port = w_res.emit_lport;
    assign o_dest_port       = w_res.dest_port;
    assign o_peer_ip         = w_res.peer_ip;
    assign o_granted_count   = w_res.granted;
    assign o_last            = w_res.last;

endmodule

@@ sim/tb_tcp_connection_table_fsm.sv @@
// ----------------------------------------------------------------------------
// TCP connection table testbench
// Drives listen, connect, send, close, consume and inbound segment commands
// into the table, mostly as well-formed handshakes and teardowns built from
// the predicted slot contents, with random noise mixed in. Every result beat
// is checked field by field against a predictor of the slot state machine.
// Register settings change between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_tcp_connection_table_fsm;
    import tcf_pkg::*;

    localparam int NSLOT = 8;
    localparam int RXCAP = 4096;
    localparam int TXCAP = 4096;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES = 16;

    class conn_scoreboard;
        t_result     pending_beats[$];
        logic [15:0] eph_base;
        logic [31:0] init_seq;
        logic [3:0]  max_conns;
        logic [10:0] max_payload;
        logic [3:0]  slot_st[NSLOT];
        logic [15:0] lport_tab[NSLOT];
        logic [31:0] pip_tab[NSLOT];
        logic [15:0] pport_tab[NSLOT];
        logic [31:0] snd_nxt[NSLOT];
        logic [31:0] snd_una[NSLOT];
        logic [31:0] rcv_nxt[NSLOT];
        int          rx_fill[NSLOT];
        int          tx_fill[NSLOT];
        int          errors;
        int          beats_seen;
        int          emits_seen;

        function new();
            eph_base = RST_EPH_BASE;
            init_seq = RST_INIT_SEQ;
            max_conns = RST_MAX_CONNS;
            max_payload = RST_MAX_PAYLOAD;
            for (int i = 0; i < NSLOT; i++) clear_slot(i);
            errors = 0;
            beats_seen = 0;
            emits_seen = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [31:0] data);
            case (idx)
                CFG_EPH_BASE:    eph_base = data[15:0];
                CFG_INIT_SEQ:    init_seq = data;
                CFG_MAX_CONNS:   max_conns = data[3:0];
                CFG_MAX_PAYLOAD: max_payload = data[10:0];
                default: ;
            endcase
        endfunction

        function void clear_slot(int i);
            slot_st[i] = ST_UNUSED;
            lport_tab[i] = '0;
            pip_tab[i] = '0;
            pport_tab[i] = '0;
            snd_nxt[i] = '0;
            snd_una[i] = '0;
            rcv_nxt[i] = '0;
            rx_fill[i] = 0;
            tx_fill[i] = 0;
        endfunction

        function int grab_slot();
            int used;
            used = 0;
            for (int i = 0; i < NSLOT; i++) if (slot_st[i] != ST_UNUSED) used++;
            if (used >= max_conns) return NSLOT;
            for (int i = 0; i < NSLOT; i++) begin
                if (slot_st[i] == ST_UNUSED) begin
                    clear_slot(i);
                    return i;
                end
            end
            return NSLOT;
        endfunction

        function void push_beat(logic [2:0] sts, int sl, logic ev, logic [7:0] fl,
                                logic [31:0] sq, logic [31:0] ak, logic [15:0] lp,
                                logic [15:0] pp, logic [31:0] pi, logic [12:0] gr);
            t_result r;
            r.status = sts;
            r.slot = sl[2:0];
            r.emit_valid = ev;
            r.emit_flags = fl;
            r.emit_seq = sq;
            r.emit_ack = ak;
            r.emit_lport = lp;
            r.dest_port = pp;
            r.peer_ip = pi;
            r.granted = gr;
            r.last = 1'b0;
            pending_beats.push_back(r);
        endfunction

        function void segment_out(int i, logic [7:0] fl);
            push_beat(STS_OK, i, 1'b1, fl, snd_nxt[i], rcv_nxt[i], lport_tab[i],
                      pport_tab[i], pip_tab[i], '0);
        endfunction

        function void note_command(t_item it);
            int          n0;
            int          idx;
            int          room;
            int          cp;
            int          g;
            logic [2:0]  sts;
            int          sl;
            logic [3:0]  st;
            n0 = pending_beats.size();
            sts = STS_OK;
            sl = 0;
            case (it.cmd)
                CMD_SEG: begin
                    idx = NSLOT;
                    for (int i = 0; i < NSLOT; i++) begin
                        if (slot_st[i] != ST_UNUSED && lport_tab[i] == it.lport &&
                            (slot_st[i] == ST_LISTEN ||
                             (pport_tab[i] == it.rport && pip_tab[i] == it.rip))) begin
                            idx = i;
                            break;
                        end
                    end
                    if (idx >= NSLOT) begin
                        sts = STS_NOT_FOUND;
                    end else begin
                        sl = idx;
                        st = slot_st[idx];
                        case (st)
                            ST_LISTEN: if (it.flags & FL_SYN) begin
                                pip_tab[idx] = it.rip;
                                pport_tab[idx] = it.rport;
                                rcv_nxt[idx] = it.seq + 1;
                                snd_nxt[idx] = init_seq + idx;
                                snd_una[idx] = snd_nxt[idx];
                                slot_st[idx] = ST_SYN_RCVD;
                                segment_out(idx, FL_SYN | FL_ACK);
                                snd_nxt[idx] += 1;
                            end
                            ST_SYN_SENT: if ((it.flags & (FL_SYN | FL_ACK)) ==
                                             (FL_SYN | FL_ACK)) begin
                                rcv_nxt[idx] = it.seq + 1;
                                snd_una[idx] = it.ack;
                                slot_st[idx] = ST_ESTAB;
                                segment_out(idx, FL_ACK);
                            end
                            ST_SYN_RCVD: if (it.flags & FL_ACK) begin
                                snd_una[idx] = it.ack;
                                slot_st[idx] = ST_ESTAB;
                            end
                            ST_ESTAB: begin
                                if (it.plen != 0) begin
                                    room = (rx_fill[idx] < RXCAP) ? RXCAP - rx_fill[idx] : 0;
                                    cp = (it.plen < room) ? it.plen : room;
                                    rx_fill[idx] += cp;
                                    rcv_nxt[idx] = it.seq + it.plen;
                                    segment_out(idx, FL_ACK);
                                end
                                if (it.flags & FL_FIN) begin
                                    rcv_nxt[idx] += 1;
                                    slot_st[idx] = ST_CLOSE_WAIT;
                                    segment_out(idx, FL_ACK);
                                end
                                if (it.flags & FL_ACK) snd_una[idx] = it.ack;
                            end
                            ST_FIN_WAIT: if (it.flags & FL_FIN) begin
                                rcv_nxt[idx] += 1;
                                segment_out(idx, FL_ACK);
                                clear_slot(idx);
                            end
                            ST_LAST_ACK: if (it.flags & FL_ACK) clear_slot(idx);
                            default: ;
                        endcase
                    end
                end
                CMD_LISTEN, CMD_CONNECT: begin
                    if ((it.cmd == CMD_LISTEN && it.lport == 0) ||
                        (it.cmd == CMD_CONNECT && it.rport == 0)) begin
                        sts = STS_BAD_ARG;
                    end else begin
                        idx = grab_slot();
                        if (idx >= NSLOT) begin
                            sts = STS_NO_ROOM;
                        end else if (it.cmd == CMD_LISTEN) begin
                            sl = idx;
                            slot_st[idx] = ST_LISTEN;
                            lport_tab[idx] = it.lport;
                        end else begin
                            sl = idx;
                            slot_st[idx] = ST_SYN_SENT;
                            lport_tab[idx] = 16'(eph_base + idx);
                            pip_tab[idx] = it.rip;
                            pport_tab[idx] = it.rport;
                            snd_nxt[idx] = init_seq + idx;
                            snd_una[idx] = snd_nxt[idx];
                            rcv_nxt[idx] = '0;
                            segment_out(idx, FL_SYN);
                            snd_nxt[idx] += 1;
                        end
                    end
                end
                CMD_SEND: begin
                    idx = it.sel;
                    sl = idx;
                    if (slot_st[idx] != ST_ESTAB) begin
                        sts = STS_BAD_STATE;
                    end else if (tx_fill[idx] + it.bcount > TXCAP) begin
                        sts = STS_NO_ROOM;
                    end else begin
                        tx_fill[idx] += it.bcount;
                        if (it.bcount > max_payload) begin
                            sts = STS_TOO_BIG;
                        end else begin
                            segment_out(idx, FL_PSH | FL_ACK);
                            snd_nxt[idx] += it.bcount;
                        end
                    end
                end
                CMD_CLOSE: begin
                    idx = it.sel;
                    sl = idx;
                    st = slot_st[idx];
                    if (st == ST_UNUSED) begin
                        sts = STS_BAD_ARG;
                    end else if (st == ST_LISTEN || st == ST_SYN_SENT) begin
                        clear_slot(idx);
                    end else if (st == ST_ESTAB || st == ST_SYN_RCVD ||
                                 st == ST_CLOSE_WAIT) begin
                        segment_out(idx, FL_FIN | FL_ACK);
                        snd_nxt[idx] += 1;
                        slot_st[idx] = (st == ST_CLOSE_WAIT) ? ST_LAST_ACK : ST_FIN_WAIT;
                    end
                end
                CMD_CONSUME: begin
                    idx = it.sel;
                    sl = idx;
                    if (slot_st[idx] == ST_UNUSED) begin
                        sts = STS_BAD_STATE;
                    end else if (rx_fill[idx] == 0) begin
                        sts = STS_NO_DATA;
                    end else begin
                        g = (rx_fill[idx] < it.bcount) ? rx_fill[idx] : it.bcount;
                        rx_fill[idx] -= g;
                        push_beat(STS_OK, idx, 1'b0, '0, '0, '0, '0, pport_tab[idx],
                                  pip_tab[idx], g[12:0]);
                    end
                end
                default: sts = STS_BAD_ARG;
            endcase
            if (pending_beats.size() == n0)
                push_beat(sts, sl, 1'b0, '0, '0, '0, '0, '0, '0, '0);
            pending_beats[pending_beats.size() - 1].last = 1'b1;
        endfunction

        function bit field_ok(string name, logic [31:0] e, logic [31:0] a);
            if (e !== a) begin
                $display("%0t: mismatch on %s: expected %0h, actual %0h", $time, name, e, a);
                return 0;
            end
            return 1;
        endfunction

        function void check_beat(t_result a);
            t_result e;
            bit ok;
            beats_seen++;
            if (a.emit_valid === 1'b1) emits_seen++;
            if (pending_beats.size() == 0) begin
                $display("%0t: unexpected result beat: expected none, actual %0h", $time, a);
                errors++;
                return;
            end
            e = pending_beats.pop_front();
            ok = 1;
            ok &= field_ok("status", e.status, a.status);
            ok &= field_ok("slot", e.slot, a.slot);
            ok &= field_ok("emit_valid", e.emit_valid, a.emit_valid);
            ok &= field_ok("emit_flags", e.emit_flags, a.emit_flags);
            ok &= field_ok("emit_seq", e.emit_seq, a.emit_seq);
            ok &= field_ok("emit_ack", e.emit_ack, a.emit_ack);
            ok &= field_ok("emit_local_port", e.emit_lport, a.emit_lport);
            ok &= field_ok("dest_port", e.dest_port, a.dest_port);
            ok &= field_ok("peer_ip", e.peer_ip, a.peer_ip);
            ok &= field_ok("granted_count", e.granted, a.granted);
            ok &= field_ok("last", e.last, a.last);
            if (!ok) errors++;
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;
    logic        push = 1'b0;
    logic        full;
    logic [2:0]  i_cmd = '0;
    logic [2:0]  i_slot_sel = '0;
    logic [15:0] i_local_port = '0;
    logic [31:0] i_remote_ip = '0;
    logic [15:0] i_remote_port = '0;
    logic [31:0] i_seq_number = '0;
    logic [31:0] i_ack_number = '0;
    logic [7:0]  i_segment_flags = '0;
    logic [15:0] i_payload_length = '0;
    logic [15:0] i_byte_count = '0;
    logic        empty;
    logic        pop = 1'b0;
    logic [2:0]  o_status;
    logic [2:0]  o_slot;
    logic        o_emit_valid;
    logic [7:0]  o_emit_flags;
    logic [31:0] o_emit_seq;
    logic [31:0] o_emit_ack;
    logic [15:0] o_emit_local_port;
    logic [15:0] o_dest_port;
    logic [31:0] o_peer_ip;
    logic [12:0] o_granted_count;
    logic        o_last;

    conn_scoreboard sb = new();
    bit idling_on = 1'b1;
    int idle_cycles = 0;
    int items_sent = 0;
    int stall_left = 0;

    tcp_connection_table_fsm uut (.*);

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        t_result r;
        if (i_rst_n && pop && !empty) begin
            r.status = o_status;
            r.slot = o_slot;
            r.emit_valid = o_emit_valid;
            r.emit_flags = o_emit_flags;
            r.emit_seq = o_emit_seq;
            r.emit_ack = o_emit_ack;
            r.emit_lport = o_emit_local_port;
            r.dest_port = o_dest_port;
            r.peer_ip = o_peer_ip;
            r.granted = o_granted_count;
            r.last = o_last;
            sb.check_beat(r);
            idle_cycles = 0;
        end
        if (stall_left > 0) begin
            stall_left--;
            pop <= 1'b0;
        end else if (idling_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 7) - 1;
            pop <= 1'b0;
        end else begin
            pop <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        idle_cycles++;
        if (idle_cycles > WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired with %0d beats outstanding", $time,
                     sb.pending_beats.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic issue(t_item it);
        i_cmd <= it.cmd;
        i_slot_sel <= it.sel;
        i_local_port <= it.lport;
        i_remote_ip <= it.rip;
        i_remote_port <= it.rport;
        i_seq_number <= it.seq;
        i_ack_number <= it.ack;
        i_segment_flags <= it.flags;
        i_payload_length <= it.plen;
        i_byte_count <= it.bcount;
        push <= 1'b1;
        do @(posedge i_clk); while (full);
        sb.note_command(it);
        items_sent++;
        idle_cycles = 0;
        if (idling_on && $urandom_range(0, 4) == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        push <= 1'b0;
        while (sb.pending_beats.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.write_reg(idx, data);
        @(posedge i_clk);
    endtask

    function automatic t_item blank(logic [2:0] c);
        t_item it;
        it = '0;
        it.cmd = c;
        return it;
    endfunction

    function automatic t_item seg(logic [15:0] lp, logic [31:0] ip, logic [15:0] rp,
                                  logic [7:0] fl, logic [15:0] pl);
        t_item it;
        it = blank(CMD_SEG);
        it.lport = lp;
        it.rip = ip;
        it.rport = rp;
        it.flags = fl;
        it.plen = pl;
        it.seq = $urandom();
        it.ack = $urandom();
        return it;
    endfunction

    function automatic t_item with_sel(logic [2:0] c, int s, logic [15:0] bc);
        t_item it;
        it = blank(c);
        it.sel = s[2:0];
        it.bcount = bc;
        return it;
    endfunction

    function automatic logic [15:0] pick_len();
        case ($urandom_range(0, 9))
            0:       return 16'hFFFF;
            1:       return 16'($urandom());
            2:       return 16'd0;
            default: return 16'($urandom_range(1, 1500));
        endcase
    endfunction

    function automatic t_item make_random();
        t_item it;
        int    s;
        int    tries;
        logic [7:0] fl;
        it = '0;
        it.cmd = 3'($urandom());
        it.sel = 3'($urandom());
        it.lport = 16'($urandom());
        it.rip = $urandom();
        it.rport = 16'($urandom());
        it.seq = $urandom();
        it.ack = $urandom();
        it.flags = 8'($urandom());
        it.plen = 16'($urandom());
        it.bcount = 16'($urandom());
        if ($urandom_range(0, 9) < 2) return it;
        if ($urandom_range(0, 9) < 3) begin
            if ($urandom_range(0, 1)) begin
                it.cmd = CMD_LISTEN;
                it.lport = $urandom_range(0, 3) == 0 ? 16'($urandom()) :
                           16'(16'd80 + $urandom_range(0, 3));
            end else begin
                it.cmd = CMD_CONNECT;
                it.rport = $urandom_range(0, 15) == 0 ? 16'd0 : 16'($urandom());
            end
            return it;
        end
        s = $urandom_range(0, NSLOT - 1);
        tries = 0;
        while (sb.slot_st[s] == ST_UNUSED && tries < 8) begin
            s = (s + 1) % NSLOT;
            tries++;
        end
        if ($urandom_range(0, 2) == 0) begin
            case ($urandom_range(0, 2))
                0: it = with_sel(CMD_SEND, s, $urandom_range(0, 3) == 0 ?
                                 16'($urandom()) : 16'($urandom_range(0, 1600)));
                1: it = with_sel(CMD_CLOSE, s, 16'd0);
                default: it = with_sel(CMD_CONSUME, s, pick_len());
            endcase
            return it;
        end
        case (sb.slot_st[s])
            ST_LISTEN:    fl = FL_SYN | (8'($urandom()) & 8'hED);
            ST_SYN_SENT:  fl = FL_SYN | FL_ACK | ($urandom_range(0, 1) ? 8'h08 : 8'h00);
            ST_SYN_RCVD:  fl = FL_ACK;
            ST_ESTAB:     fl = FL_ACK | FL_PSH | ($urandom_range(0, 5) == 0 ? FL_FIN : 8'h00);
            ST_FIN_WAIT:  fl = FL_FIN | FL_ACK;
            ST_LAST_ACK:  fl = FL_ACK;
            default:      fl = 8'($urandom());
        endcase
        if ($urandom_range(0, 7) == 0) fl = 8'($urandom());
        if (sb.slot_st[s] == ST_LISTEN) begin
            it = seg(sb.lport_tab[s], $urandom_range(0, 3),
                     16'(16'd1000 + $urandom_range(0, 3)), fl, 16'd0);
        end else begin
            it = seg(sb.lport_tab[s], sb.pip_tab[s], sb.pport_tab[s], fl,
                     sb.slot_st[s] == ST_ESTAB ? pick_len() : 16'd0);
        end
        return it;
    endfunction

    initial begin
        t_item it;
        int    sl;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Passive open, data both ways, remote close.
        it = blank(CMD_LISTEN);
        it.lport = 16'd80;
        issue(it);
        issue(seg(16'd80, 32'hC0A8_0001, 16'd5000, FL_SYN, 16'd0));
        issue(seg(16'd80, 32'hC0A8_0001, 16'd5000, FL_ACK, 16'd0));
        issue(seg(16'd80, 32'hC0A8_0001, 16'd5000, FL_ACK | FL_PSH, 16'd100));
        issue(with_sel(CMD_CONSUME, 0, 16'd50));
        issue(with_sel(CMD_SEND, 0, 16'd10));
        issue(with_sel(CMD_SEND, 0, 16'd2000));
        issue(with_sel(CMD_SEND, 0, 16'hFFFF));
        issue(seg(16'd80, 32'hC0A8_0001, 16'd5000, FL_ACK | FL_FIN, 16'd0));
        issue(with_sel(CMD_CLOSE, 0, 16'd0));
        issue(seg(16'd80, 32'hC0A8_0001, 16'd5000, FL_ACK, 16'd0));
        // Bad arguments and unused slots.
        it = blank(CMD_CONNECT);
        issue(it);
        issue(blank(CMD_LISTEN));
        issue(blank(3'd6));
        it = blank(3'd7);
        it.sel = 3'd7;
        issue(it);
        issue(with_sel(CMD_CLOSE, 5, 16'd0));
        issue(with_sel(CMD_SEND, 7, 16'd0));
        issue(with_sel(CMD_CONSUME, 6, 16'hFFFF));
        issue(seg(16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF, 16'hFFFF));
        // Active open and local close.
        it = blank(CMD_CONNECT);
        it.rip = 32'hFFFF_FFFF;
        it.rport = 16'hFFFF;
        issue(it);
        drain();
        sl = 0;
        issue(seg(16'(sb.eph_base + sl), 32'hFFFF_FFFF, 16'hFFFF, FL_SYN | FL_ACK,
                  16'hFFFF));
        issue(seg(16'(sb.eph_base + sl), 32'hFFFF_FFFF, 16'hFFFF, FL_ACK, 16'hFFFF));
        issue(with_sel(CMD_CLOSE, sl, 16'd0));
        issue(with_sel(CMD_CLOSE, sl, 16'd0));
        issue(seg(16'(sb.eph_base + sl), 32'hFFFF_FFFF, 16'hFFFF, FL_FIN, 16'd0));

        for (int ph = 0; ph < 6; ph++) begin
            drain();
            case (ph)
                0: ;
                1: begin
                    write_reg(CFG_EPH_BASE, 32'hFFFF_FFFC);
                    write_reg(CFG_INIT_SEQ, 32'hFFFF_FFFF);
                    write_reg(CFG_MAX_CONNS, 32'd1);
                    write_reg(CFG_MAX_PAYLOAD, 32'd0);
                end
                2: begin
                    write_reg(CFG_EPH_BASE, 32'd0);
                    write_reg(CFG_INIT_SEQ, 32'd0);
                    write_reg(CFG_MAX_CONNS, 32'd0);
                    write_reg(CFG_MAX_PAYLOAD, 32'h7FF);
                end
                3: begin
                    write_reg(CFG_EPH_BASE, $urandom());
                    write_reg(CFG_INIT_SEQ, $urandom());
                    write_reg(CFG_MAX_CONNS, 32'hF);
                    write_reg(CFG_MAX_PAYLOAD, $urandom());
                end
                4: begin
                    write_reg(CFG_MAX_CONNS, 32'd3);
                    write_reg(CFG_MAX_PAYLOAD, 32'd500);
                end
                default: begin
                    write_reg(CFG_EPH_BASE, 32'(RST_EPH_BASE));
                    write_reg(CFG_INIT_SEQ, RST_INIT_SEQ);
                    write_reg(CFG_MAX_CONNS, 32'(RST_MAX_CONNS));
                    write_reg(CFG_MAX_PAYLOAD, 32'(RST_MAX_PAYLOAD));
                    idling_on = 1'b0;
                end
            endcase
            for (int k = 0; k < 172; k++) begin
                if (ph == 3 && k == 80) begin
                    push <= 1'b0;
                    while (sb.pending_beats.size() != 0) @(posedge i_clk);
                end
                issue(make_random());
            end
        end
        push <= 1'b0;
        while (sb.pending_beats.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d commands and %0d result beats, %0d of them segments,",
                 items_sent, sb.beats_seen, sb.emits_seen);
        $display("over six register settings including the extremes of each register.");
        if (sb.errors == 0 && sb.pending_beats.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

@@ files.f @@
sv/tcf_pkg.sv
sv/tcf_front.sv
sv/tcf_back.sv
sv/tcp_connection_table_fsm.sv
sim/tb_tcp_connection_table_fsm.sv
